/* design/optical_motion_accumulator_top_assert.svh */
// ---------------------------------------------------------------------------
// optical motion accumulator assertion macros
// concurrent checks clocked on clk, disabled while arst_n is low
// ---------------------------------------------------------------------------
`ifndef OPTICAL_MOTION_ACCUMULATOR_TOP_ASSERT_SVH
`define OPTICAL_MOTION_ACCUMULATOR_TOP_ASSERT_SVH

`ifndef SYNTH

// property must hold at every clock edge out of reset
`define OMA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define OMA_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define OMA_ASSERT(lbl, prop, msg)
`define OMA_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

/* design/oma_pkg.sv */
// ---------------------------------------------------------------------------
// oma_pkg
// shared types and constants of the optical motion accumulator
// ---------------------------------------------------------------------------
`default_nettype none

package oma_pkg;

	// word function codes
	localparam logic FUNC_ACC    = 1'b0;
	localparam logic FUNC_REPORT = 1'b1;

	// field and state widths
	localparam int DELTA_W = 8;
	localparam int QUAL_W  = 8;
	localparam int SUM_W   = 16;
	localparam int QSUM_W  = 24;
	localparam int CNT_W   = 16;
	localparam int MEAN_W  = 8;

	// queue depth between front and back
	localparam int QueueDepth = 2;

	// one quotient bit per divider step
	localparam int DivSteps = QSUM_W;

	// classified word carried from front to back
	typedef struct packed {
		logic                      report;
		logic signed [DELTA_W-1:0] dx;
		logic signed [DELTA_W-1:0] dy;
		logic [QUAL_W-1:0]         qual;
	} word_t;

	// queue status
	typedef struct packed {
		logic valid;
		logic full;
	} q_stat_t;

	// divider request
	typedef struct packed {
		logic              start;
		logic [QSUM_W-1:0] dividend;
		logic [CNT_W-1:0]  divisor;
	} div_req_t;

	// divider response
	typedef struct packed {
		logic              busy;
		logic              done;
		logic [MEAN_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

/* design/oma_front.sv */
// ---------------------------------------------------------------------------
// oma_front
// input stage: registers each word, classifies it and pushes it to the queue
// ---------------------------------------------------------------------------
`default_nettype none

module oma_front
	import oma_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      func,
	input  wire logic signed [DELTA_W-1:0] delta_x,
	input  wire logic signed [DELTA_W-1:0] delta_y,
	input  wire logic [QUAL_W-1:0]         surface_quality,
	input  wire q_stat_t                   q_stat,
	output logic                           q_push,
	output word_t                          q_word
);

	logic  valid_s1;
	word_t word_s1;
	logic  accept;

	// push whenever the queue has room; take a new word when the stage frees
	assign q_push   = valid_s1 && !q_stat.full;
	assign in_stall = valid_s1 && q_stat.full;
	assign accept   = in_valid && !in_stall;
	assign q_word   = word_s1;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage payload with function decode
	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1.report <= (func == FUNC_REPORT);
			word_s1.dx     <= delta_x;
			word_s1.dy     <= delta_y;
			word_s1.qual   <= surface_quality;
		end
	end

endmodule

`default_nettype wire

/* design/oma_queue.sv */
// ---------------------------------------------------------------------------
// oma_queue
// short first-in first-out queue of words between front and back
// ---------------------------------------------------------------------------
`default_nettype none

module oma_queue
	import oma_pkg::*;
#(
	parameter int DEPTH = QueueDepth
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire word_t push_word,
	input  wire logic  pop,
	output word_t      pop_word,
	output q_stat_t    stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	word_t            entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign stat.valid = (count_q != '0);
	assign stat.full  = (count_q == FULL_CNT);
	assign pop_word   = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

`default_nettype wire

/* design/oma_div.sv */
// ---------------------------------------------------------------------------
// oma_div
// restoring divider, one quotient bit per cycle, quotient clamped to 8 bits
// ---------------------------------------------------------------------------
`default_nettype none

module oma_div
	import oma_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	localparam int STEP_W = $clog2(DivSteps);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DivSteps - 1);

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	logic [QSUM_W-1:0]   dvd_q;
	logic [QSUM_W-1:0]   quo_q;
	logic [CNT_W:0]      rem_q;
	logic [CNT_W-1:0]    dvs_q;
	logic [CNT_W:0]      trial;
	logic                fits;

	// one restoring step
	always_comb begin
		trial = {rem_q[CNT_W-1:0], dvd_q[QSUM_W-1]};
		fits  = (trial >= {1'b0, dvs_q});
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[QSUM_W-2:0], 1'b0};
			rem_q <= fits ? (trial - {1'b0, dvs_q}) : trial;
			quo_q <= {quo_q[QSUM_W-2:0], fits};
		end
	end

	// clamp quotient to the mean range
	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = (|quo_q[QSUM_W-1:MEAN_W]) ? '1 : quo_q[MEAN_W-1:0];

endmodule

`default_nettype wire

/* design/oma_back.sv */
// ---------------------------------------------------------------------------
// oma_back
// executes queued words: saturating sums, report snapshot, output register
// ---------------------------------------------------------------------------
`default_nettype none

module oma_back
	import oma_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire q_stat_t                  q_stat,
	input  wire word_t                    q_word,
	output logic                          q_pop,
	output div_req_t                      div_req,
	input  wire div_rsp_t                 div_rsp,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [SUM_W-1:0]       sum_x,
	output logic signed [SUM_W-1:0]       sum_y,
	output logic [MEAN_W-1:0]             mean_quality
);

	logic signed [SUM_W-1:0] acc_x_q;
	logic signed [SUM_W-1:0] acc_y_q;
	logic [QSUM_W-1:0]       qsum_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [SUM_W-1:0] snap_x_q;
	logic signed [SUM_W-1:0] snap_y_q;
	logic [MEAN_W-1:0]       mean_q;
	logic                    pend_q;
	logic                    mean_rdy_q;
	logic                    out_valid_q;
	logic signed [SUM_W-1:0] sum_x_q;
	logic signed [SUM_W-1:0] sum_y_q;
	logic [MEAN_W-1:0]       mean_out_q;

	logic signed [SUM_W:0]   raw_x;
	logic signed [SUM_W:0]   raw_y;
	logic signed [SUM_W-1:0] next_x;
	logic signed [SUM_W-1:0] next_y;
	logic [QSUM_W:0]         raw_q;
	logic [QSUM_W-1:0]       next_q;
	logic                    moving;
	logic                    do_acc;
	logic                    do_rep;
	logic                    load;

	// a report waits until the previous one has reached the output register
	assign q_pop  = q_stat.valid && (!q_word.report || !pend_q);
	assign do_acc = q_pop && !q_word.report;
	assign do_rep = q_pop && q_word.report;
	assign load   = pend_q && mean_rdy_q && (!out_valid_q || !out_stall);

	// saturating sums
	always_comb begin
		raw_x  = {acc_x_q[SUM_W-1], acc_x_q} + (SUM_W+1)'(q_word.dx);
		raw_y  = {acc_y_q[SUM_W-1], acc_y_q} + (SUM_W+1)'(q_word.dy);
		next_x = (raw_x[SUM_W] != raw_x[SUM_W-1]) ?
			{raw_x[SUM_W], {(SUM_W-1){~raw_x[SUM_W]}}} : raw_x[SUM_W-1:0];
		next_y = (raw_y[SUM_W] != raw_y[SUM_W-1]) ?
			{raw_y[SUM_W], {(SUM_W-1){~raw_y[SUM_W]}}} : raw_y[SUM_W-1:0];
		raw_q  = {1'b0, qsum_q} + (QSUM_W+1)'(q_word.qual);
		next_q = raw_q[QSUM_W] ? '1 : raw_q[QSUM_W-1:0];
		moving = (next_x != '0) || (next_y != '0);
	end

	// divider request on a report with a nonzero count
	assign div_req.start    = do_rep && (cnt_q != '0);
	assign div_req.dividend = qsum_q;
	assign div_req.divisor  = cnt_q;

	// accumulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
			qsum_q  <= '0;
			cnt_q   <= '0;
		end else if (do_rep) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
			qsum_q  <= '0;
			cnt_q   <= '0;
		end else if (do_acc) begin
			acc_x_q <= next_x;
			acc_y_q <= next_y;
			qsum_q  <= next_q;
			if (moving && (cnt_q != '1)) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// report tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= 1'b0;
			mean_rdy_q <= 1'b0;
		end else if (do_rep) begin
			pend_q     <= 1'b1;
			mean_rdy_q <= (cnt_q == '0);
		end else if (load) begin
			pend_q     <= 1'b0;
			mean_rdy_q <= 1'b0;
		end else if (div_rsp.done) begin
			mean_rdy_q <= 1'b1;
		end
	end

	// report snapshot and mean
	always_ff @(posedge clk) begin
		if (do_rep) begin
			snap_x_q <= acc_x_q;
			snap_y_q <= acc_y_q;
			mean_q   <= '0;
		end else if (div_rsp.done) begin
			mean_q <= div_rsp.quotient;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			sum_x_q    <= snap_x_q;
			sum_y_q    <= snap_y_q;
			mean_out_q <= mean_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sum_x        = sum_x_q;
	assign sum_y        = sum_y_q;
	assign mean_quality = mean_out_q;

endmodule

`default_nettype wire

/* design/optical_motion_accumulator_top.sv */
// ---------------------------------------------------------------------------
// optical_motion_accumulator_top
// Input channel (in_valid / in_stall) takes one word per sensor sample or
// report request: func 0 adds delta_x, delta_y and surface_quality to
// saturating sums, func 1 asks for a report and clears all sums.
// Output channel (out_valid / out_stall) returns one word per report:
// sum_x, sum_y and the truncated mean quality (0 when no moving sample).
// Sample words are absorbed at one per cycle and give no output word,
// unless a report held at the queue head blocks them. A report with a
// nonzero moving count runs a 24-step restoring divider, one quotient bit
// per cycle, before its word is loaded; a zero count skips the divider.
// A report is held at the queue head until the previous one has reached
// the output register, where a finished report waits while out_stall is
// high; the input side keeps taking words until the queue and input stage
// fill. Reset clears all sums, the queue and the output register at once.
// ---------------------------------------------------------------------------
`default_nettype none

module optical_motion_accumulator_top
	import oma_pkg::*;
#(
	parameter int QUEUE_DEPTH = QueueDepth
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      func,
	input  wire logic signed [DELTA_W-1:0] delta_x,
	input  wire logic signed [DELTA_W-1:0] delta_y,
	input  wire logic [QUAL_W-1:0]         surface_quality,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic signed [SUM_W-1:0]        sum_x,
	output logic signed [SUM_W-1:0]        sum_y,
	output logic [MEAN_W-1:0]              mean_quality
);

`include "optical_motion_accumulator_top_assert.svh"

	q_stat_t  q_stat;
	logic     q_push;
	logic     q_pop;
	word_t    push_word;
	word_t    pop_word;
	div_req_t div_req;
	div_rsp_t div_rsp;

	// accept and classify
	oma_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.delta_x         (delta_x),
		.delta_y         (delta_y),
		.surface_quality (surface_quality),
		.q_stat          (q_stat),
		.q_push          (q_push),
		.q_word          (push_word)
	);

	// decoupling queue
	oma_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_word (push_word),
		.pop       (q_pop),
		.pop_word  (pop_word),
		.stat      (q_stat)
	);

	// execute
	oma_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.q_word       (pop_word),
		.q_pop        (q_pop),
		.div_req      (div_req),
		.div_rsp      (div_rsp),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sum_x        (sum_x),
		.sum_y        (sum_y),
		.mean_quality (mean_quality)
	);

	// mean divider
	oma_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// internal checks
	`OMA_ASSERT_NEVER(a_push_full, q_push && q_stat.full && !q_pop, "push into full queue")
	`OMA_ASSERT(a_pop_valid, q_pop |-> q_stat.valid, "pop from empty queue")
	`OMA_ASSERT(a_div_idle, div_req.start |-> !div_rsp.busy, "divider restarted while busy")
	`OMA_ASSERT(a_div_done, div_rsp.done |-> $past(div_rsp.busy), "divider done without run")

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the optical motion accumulator. A queue of sensor
// and report words feeds a clocked driver; a clocked monitor checks every
// report word against a running model of the saturating sums, the moving
// sample count and the clamped mean, with random gaps and stalls on both
// channels and one long run that drives both motion sums into saturation.
// ---------------------------------------------------------------------------
module tb_top;
	import oma_pkg::*;

	// one queued input word with its lead-in gap
	typedef struct {
		logic                      f;
		logic signed [DELTA_W-1:0] dx;
		logic signed [DELTA_W-1:0] dy;
		logic [QUAL_W-1:0]         q;
		int unsigned               gap;
		bit                        drain;
	} sensor_word_t;

	// one expected report word
	typedef struct packed {
		logic signed [SUM_W-1:0] sx;
		logic signed [SUM_W-1:0] sy;
		logic [MEAN_W-1:0]       mean;
	} report_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid = 1'b0;
	logic func = FUNC_ACC;
	logic signed [DELTA_W-1:0] delta_x = '0;
	logic signed [DELTA_W-1:0] delta_y = '0;
	logic [QUAL_W-1:0] surface_quality = '0;
	logic out_stall = 1'b0;
	wire logic in_stall;
	wire logic out_valid;
	wire logic signed [SUM_W-1:0] sum_x;
	wire logic signed [SUM_W-1:0] sum_y;
	wire logic [MEAN_W-1:0] mean_quality;

	sensor_word_t pending_words[$];
	report_t expected_reports[$];

	// running copy of the block state
	logic signed [SUM_W-1:0] est_x;
	logic signed [SUM_W-1:0] est_y;
	logic [QSUM_W-1:0] est_qsum;
	logic [CNT_W-1:0] est_count;

	int unsigned mismatches = 0;
	int unsigned words_sent = 0;
	int unsigned reports_seen = 0;
	int unsigned n_clamped_sum = 0;
	int unsigned n_clamped_mean = 0;
	int unsigned n_zero_count = 0;

	// driver and receiver bookkeeping
	int unsigned gap_left = 0;
	bit gap_armed = 0;
	int unsigned rx_wait = 0;
	bit rx_calm = 0;
	int unsigned rx_cycles = 0;
	int unsigned hold_left = 0;
	int unsigned next_hold_at = 40;

	optical_motion_accumulator_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.delta_x        (delta_x),
		.delta_y        (delta_y),
		.surface_quality(surface_quality),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.sum_x          (sum_x),
		.sum_y          (sum_y),
		.mean_quality   (mean_quality)
	);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// run limit
	initial begin
		#40_000_000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		mismatches++;
		$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	task automatic clear_estimate();
		est_x = '0;
		est_y = '0;
		est_qsum = '0;
		est_count = '0;
	endtask

	// advance the motion state by one accepted word
	task automatic track_word(input logic f, input logic signed [DELTA_W-1:0] dx,
			input logic signed [DELTA_W-1:0] dy, input logic [QUAL_W-1:0] q);
		int sx;
		int sy;
		longint unsigned qs;
		int unsigned mean;
		report_t rep;
		if (f == FUNC_ACC) begin
			sx = int'(est_x) + int'(dx);
			sy = int'(est_y) + int'(dy);
			if (sx > 32767) sx = 32767;
			if (sx < -32768) sx = -32768;
			if (sy > 32767) sy = 32767;
			if (sy < -32768) sy = -32768;
			est_x = SUM_W'(sx);
			est_y = SUM_W'(sy);
			qs = longint'(est_qsum) + longint'(q);
			if (qs > 64'hFF_FFFF) qs = 64'hFF_FFFF;
			est_qsum = QSUM_W'(qs);
			if ((est_x != 0 || est_y != 0) && est_count != 16'hFFFF)
				est_count = est_count + 1'b1;
		end else begin
			mean = 0;
			if (est_count != 0) begin
				mean = est_qsum / est_count;
				if (mean > 255) mean = 255;
			end else begin
				n_zero_count++;
			end
			if (mean == 255) n_clamped_mean++;
			if (est_x == 16'sh7FFF || est_x == -16'sh8000 || est_y == 16'sh7FFF
					|| est_y == -16'sh8000)
				n_clamped_sum++;
			rep.sx = est_x;
			rep.sy = est_y;
			rep.mean = MEAN_W'(mean);
			expected_reports.push_back(rep);
			clear_estimate();
		end
	endtask

	task automatic queue_word(input logic f, input int dx, input int dy, input int q,
			input int unsigned gap, input bit drain = 0);
		sensor_word_t w;
		w.f = f;
		w.dx = DELTA_W'(dx);
		w.dy = DELTA_W'(dy);
		w.q = QUAL_W'(q);
		w.gap = gap;
		w.drain = drain;
		pending_words.push_back(w);
	endtask

	// mostly short gaps, a few long ones, none in calm stretches
	function automatic int unsigned pick_gap(input bit calm);
		int unsigned r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int pick_delta();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 20) return 0;
		if (r < 40) begin
			case ($urandom_range(0, 3))
				0: return 127;
				1: return -128;
				2: return 1;
				default: return -1;
			endcase
		end
		return int'($signed(DELTA_W'($urandom)));
	endfunction

	function automatic int pick_quality();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) return 0;
		if (r == 1) return 255;
		return $urandom_range(0, 255);
	endfunction

	// stimulus and end of run
	initial begin
		int unsigned burst;
		int unsigned n;
		int unsigned kind;
		int unsigned start_size;
		int dx;
		int dy;
		int sgn;
		bit calm;

		arst_n = 1'b0;
		clear_estimate();

		// directed: report from reset, nothing moving
		queue_word(FUNC_REPORT, 0, 0, 0, 0);
		// field extremes that end off zero
		queue_word(FUNC_ACC, 127, -128, 255, 0);
		queue_word(FUNC_ACC, -128, 127, 0, 1);
		queue_word(FUNC_REPORT, 0, 0, 0, 0);
		// still samples carry quality but are never counted: mean stays 0
		queue_word(FUNC_ACC, 0, 0, 200, 0);
		queue_word(FUNC_ACC, 0, 0, 255, 0);
		queue_word(FUNC_REPORT, 0, 0, 0, 2);
		// motion that returns to zero leaves one counted sample: mean clamps
		queue_word(FUNC_ACC, 5, 0, 10, 0);
		queue_word(FUNC_ACC, -5, 0, 250, 0);
		queue_word(FUNC_REPORT, 0, 0, 0, 0);
		// report payload is ignored
		queue_word(FUNC_REPORT, -1, 127, 255, 0);
		queue_word(FUNC_REPORT, -128, -128, 0, 3);
		// y-only motion, then an even mean
		queue_word(FUNC_ACC, 0, 1, 1, 0);
		queue_word(FUNC_ACC, 0, -1, 3, 0);
		queue_word(FUNC_ACC, 1, 0, 8, 0);
		queue_word(FUNC_REPORT, 127, 0, 0, 0);
		// back to back reports
		queue_word(FUNC_ACC, -1, -1, 100, 0);
		queue_word(FUNC_REPORT, 0, 0, 0, 0);
		queue_word(FUNC_REPORT, 0, 0, 0, 0);

		// long unbroken run: both motion sums clamp, x high and y low
		for (int i = 0; i < 300; i++)
			queue_word(FUNC_ACC, 127, -128, 255, 0);
		queue_word(FUNC_REPORT, 0, 0, 0, 0);

		// random bursts of samples closed by a report
		start_size = pending_words.size();
		burst = 0;
		while (pending_words.size() - start_size < 1580) begin
			calm = ($urandom_range(0, 7) == 0);
			kind = $urandom_range(0, 99);
			if (kind < 3) begin
				// long run in one direction that can drive x into saturation
				n = $urandom_range(258, 320);
				sgn = $urandom_range(0, 1) ? 1 : -1;
				for (int i = 0; i < n; i++) begin
					dx = (sgn > 0) ? int'($urandom_range(100, 127))
						: -int'($urandom_range(100, 128));
					dy = $urandom_range(0, 1) ? -dx / 2 : pick_delta();
					queue_word(FUNC_ACC, dx, dy, pick_quality(), pick_gap(1),
						(i == 0) && (burst % 40 == 0));
				end
			end else if (kind < 20) begin
				// back and forth: sums return to zero after each pair
				n = $urandom_range(1, 5);
				for (int i = 0; i < n; i++) begin
					dx = $urandom_range(0, 254) - 127;
					dy = $urandom_range(0, 254) - 127;
					queue_word(FUNC_ACC, dx, dy, pick_quality(), pick_gap(calm),
						(i == 0) && (burst % 40 == 0));
					queue_word(FUNC_ACC, -dx, -dy, pick_quality(), pick_gap(calm));
				end
			end else if (kind < 35) begin
				// noise: random function bits throughout
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++)
					queue_word(logic'($urandom_range(0, 1)), pick_delta(), pick_delta(),
						pick_quality(), pick_gap(calm), (i == 0) && (burst % 40 == 0));
			end else begin
				n = $urandom_range(0, 12);
				for (int i = 0; i < n; i++)
					queue_word(FUNC_ACC, pick_delta(), pick_delta(), pick_quality(),
						pick_gap(calm), (i == 0) && (burst % 40 == 0));
			end
			queue_word(FUNC_REPORT, pick_delta(), pick_delta(), pick_quality(),
				pick_gap(calm), (n == 0) && (burst % 40 == 0));
			burst++;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || in_valid || expected_reports.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("sent %0d words, checked %0d reports (%0d with clamped sums,",
			words_sent, reports_seen, n_clamped_sum);
		$display("%0d with clamped mean, %0d with no moving sample), %0d mismatches",
			n_clamped_mean, n_zero_count, mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// driver: presents queued words, waits out gaps and drain points
	always @(posedge clk or negedge arst_n) begin : drive
		bit take;
		sensor_word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
			func <= FUNC_ACC;
			delta_x <= '0;
			delta_y <= '0;
			surface_quality <= '0;
			gap_left = 0;
			gap_armed = 0;
		end else begin
			take = 0;
			if (in_valid && !in_stall) begin
				track_word(func, delta_x, delta_y, surface_quality);
				words_sent++;
			end
			if (!(in_valid && in_stall) && pending_words.size() != 0) begin
				if (!gap_armed) begin
					gap_left = pending_words[0].gap;
					gap_armed = 1;
				end
				if (gap_left != 0)
					gap_left--;
				else if (!(pending_words[0].drain && expected_reports.size() != 0))
					take = 1;
			end
			if (take) begin
				w = pending_words.pop_front();
				gap_armed = 0;
				in_valid <= 1'b1;
				func <= w.f;
				delta_x <= w.dx;
				delta_y <= w.dy;
				surface_quality <= w.q;
			end else if (!(in_valid && in_stall)) begin
				in_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, armed every so many reports
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (reports_seen >= next_hold_at) begin
			hold_left <= 400;
			next_hold_at <= next_hold_at + 300;
		end
	end

	// monitor: checks report words and drives out_stall
	always @(posedge clk or negedge arst_n) begin : watch
		report_t want;
		int unsigned r;
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_wait = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					flag_mismatch($sformatf("report with none pending: x=%0d y=%0d mean=%0d",
						sum_x, sum_y, mean_quality));
				end else begin
					want = expected_reports.pop_front();
					reports_seen++;
					if (sum_x !== want.sx)
						flag_mismatch($sformatf("sum_x got %0d want %0d", sum_x, want.sx));
					if (sum_y !== want.sy)
						flag_mismatch($sformatf("sum_y got %0d want %0d", sum_y, want.sy));
					if (mean_quality !== want.mean)
						flag_mismatch($sformatf("mean_quality got %0d want %0d",
							mean_quality, want.mean));
				end
			end

			// calm stretches come and go
			rx_cycles++;
			if (rx_cycles % 256 == 0)
				rx_calm = ($urandom_range(0, 3) == 0);

			if (hold_left != 0) begin
				out_stall <= 1'b1;
			end else if (rx_wait != 0) begin
				rx_wait--;
				out_stall <= 1'b1;
			end else if (rx_calm) begin
				out_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					out_stall <= 1'b0;
				end else begin
					out_stall <= 1'b1;
					rx_wait = (r < 95) ? $urandom_range(0, 2) : $urandom_range(15, 60);
				end
			end
		end
	end

endmodule
